### sv/fsw_pkg.sv
// Shared types, constants and helper functions for the word generator.
package fsw_pkg;

	// Command codes carried on the cmd port.
	typedef enum logic [1:0] {
		CMD_RESET = 2'd0,
		CMD_SEED  = 2'd1,
		CMD_MIX   = 2'd2,
		CMD_DRAW  = 2'd3
	} cmd_t;

	localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;
	localparam int unsigned WARM_W      = 12;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED_RD,
		ST_SEED_WR,
		ST_DRAW_RD,
		ST_DRAW_OUT,
		ST_MODD_GO,
		ST_MODD_WAIT,
		ST_RDP,
		ST_UPD,
		ST_MODB_GO,
		ST_MODB_WAIT,
		ST_RDB,
		ST_FIN,
		ST_WARM
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic latch;
		logic warm_load;
		logic seed_rd;
		logic seed_wr;
		logic draw_out;
		logic mod_start;
		logic mod_sel_b;
		logic upd;
		logic c_upd;
		logic fin;
		logic warm_step;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mod_done;
		logic step_last;
		logic rp_last;
		logic warm_zero;
		logic idx_ok;
	} dp_status_t;

	// Rotation set as {first, second, third} amount.
	function automatic logic [14:0] rot_set(input logic [1:0] sel);
		logic [14:0] r;
		case (sel)
			2'd0: r = {5'd14, 5'd9, 5'd16};
			2'd1: r = {5'd17, 5'd8, 5'd14};
			2'd2: r = {5'd17, 5'd19, 5'd30};
			2'd3: r = {5'd15, 5'd9, 5'd24};
			default: r = {5'd14, 5'd9, 5'd16};
		endcase
		return r;
	endfunction

	// 32-bit rotate left by a 5-bit amount.
	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] k);
		logic [63:0] w;
		w = {x, x} << k;
		return w[63:32];
	endfunction

endpackage

### sv/fsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsw_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/fsw_mod_unit.sv
// Reduces a 32-bit word modulo the pool size to a pool address.
module fsw_mod_unit #(
	parameter int unsigned N = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          x,
	output logic [$clog2(N)-1:0] res,
	output logic                 done
);

	localparam int unsigned AW = $clog2(N);

	logic [AW-1:0] res_q;
	logic          done_q;

	assign res  = res_q;
	assign done = done_q;

	generate
		if ((N & (N - 1)) == 0) begin : g_pow2
			// Power of two: the remainder is the low bits.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					res_q <= x[AW-1:0];
				end
			end
		end else begin : g_div
			localparam logic [AW:0] NMOD = N[AW:0];

			logic        busy_q;
			logic [1:0]  step_q;
			logic [31:0] x_q;
			logic [AW:0] r_nx;

			// Eight restoring steps per cycle, one byte at a time, MSB first.
			always_comb begin
				r_nx = {1'b0, res_q};
				for (int k = 0; k < 8; k++) begin
					r_nx = {r_nx[AW-1:0], x_q[31-k]};
					if (r_nx >= NMOD) begin
						r_nx = r_nx - NMOD;
					end
				end
			end

			// Step control.
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					step_q <= 2'd0;
					done_q <= 1'b0;
				end else begin
					done_q <= 1'b0;
					if (start) begin
						busy_q <= 1'b1;
						step_q <= 2'd0;
					end else if (busy_q) begin
						step_q <= step_q + 2'd1;
						if (step_q == 2'd3) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
				end
			end

			// Dividend shift register and partial remainder.
			always_ff @(posedge clk) begin
				if (start) begin
					x_q   <= x;
					res_q <= '0;
				end else if (busy_q) begin
					x_q   <= x_q << 8;
					res_q <= r_nx[AW-1:0];
				end
			end
		end
	endgenerate

endmodule

### sv/fsw_datapath.sv
// Datapath: pool and buffer memories, mixers, counters and the address reducer.
module fsw_datapath import fsw_pkg::*; #(
	parameter int unsigned POOL_WORDS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           ctrl,
	output dp_status_t        status,
	input  logic [6:0]        word_index,
	input  logic [31:0]       seed_word,
	input  logic [3:0]        byte_mask,
	input  logic              cfg_we,
	input  logic [WARM_W-1:0] cfg_data,
	output logic [31:0]       random_word
);

	localparam int unsigned AW       = $clog2(POOL_WORDS);
	localparam logic [AW-1:0] LAST   = AW'(POOL_WORDS - 1);
	localparam logic [10:0]   POOL_LIM = 11'(POOL_WORDS);

	logic [31:0]       mix_b_q, mix_c_q, mix_d_q, t_q;
	logic [AW-1:0]     rp_q, cnt_q, idx_q;
	logic [1:0]        rot_q;
	logic [WARM_W-1:0] warm_q, warmup_q;
	logic [31:0]       seed_q;
	logic [3:0]        mask_q;

	logic [10:0]   idx_ext;
	logic [14:0]   rs;
	logic [31:0]   pool_rdata, buf_rdata;
	logic          pool_we, buf_we;
	logic [AW-1:0] pool_waddr, pool_raddr;
	logic [31:0]   pool_wdata, buf_wdata;
	logic [31:0]   byte_m, merged, d_new, mod_x;
	logic [AW-1:0] mod_res;
	logic          mod_done;
	logic          step_last, rp_last;

	assign idx_ext   = {4'b0000, word_index};
	assign rs        = rot_set(rot_q);
	assign step_last = (cnt_q == LAST);
	assign rp_last   = (rp_q == LAST);

	// Byte-enable merge for seed writes.
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			byte_m[8*k +: 8] = {8{mask_q[k]}};
		end
		merged = (pool_rdata & ~byte_m) | (seed_q & byte_m);
	end

	assign d_new = t_q + pool_rdata;
	assign mod_x = ctrl.mod_sel_b ? mix_b_q : mix_d_q;

	// Pool memory port selection.
	always_comb begin
		pool_we    = ctrl.clear | ctrl.seed_wr | ctrl.upd;
		pool_waddr = mod_res;
		pool_wdata = mix_b_q ^ rotl32(mix_c_q, rs[9:5]);
		if (ctrl.clear) begin
			pool_waddr = cnt_q;
			pool_wdata = GOLDEN_WORD;
		end else if (ctrl.seed_wr) begin
			pool_waddr = idx_q;
			pool_wdata = merged;
		end
		pool_raddr = ctrl.seed_rd ? idx_q : mod_res;
	end

	// Output buffer write selection.
	assign buf_we    = ctrl.clear | ctrl.fin;
	assign buf_wdata = ctrl.clear ? 32'd0 : d_new;

	fsw_ram #(.WIDTH(32), .DEPTH(POOL_WORDS)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	fsw_ram #(.WIDTH(32), .DEPTH(POOL_WORDS)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q),
		.wdata (buf_wdata),
		.raddr (rp_q),
		.rdata (buf_rdata)
	);

	fsw_mod_unit #(.N(POOL_WORDS)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.mod_start),
		.x      (mod_x),
		.res    (mod_res),
		.done   (mod_done)
	);

	// Mixers, positions, rotation select and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_b_q  <= GOLDEN_WORD;
			mix_c_q  <= GOLDEN_WORD;
			mix_d_q  <= GOLDEN_WORD;
			rp_q     <= '0;
			cnt_q    <= '0;
			rot_q    <= 2'd0;
			warm_q   <= '0;
			warmup_q <= '0;
		end else begin
			if (cfg_we) begin
				warmup_q <= cfg_data;
			end
			if (ctrl.clear) begin
				mix_b_q <= GOLDEN_WORD;
				mix_c_q <= GOLDEN_WORD;
				mix_d_q <= GOLDEN_WORD;
				rp_q    <= '0;
				rot_q   <= 2'd0;
				cnt_q   <= step_last ? '0 : cnt_q + 1'b1;
			end
			if (ctrl.warm_load) begin
				warm_q <= warmup_q;
			end
			if (ctrl.draw_out || ctrl.warm_step) begin
				rp_q <= rp_last ? '0 : rp_q + 1'b1;
			end
			if (ctrl.warm_step) begin
				warm_q <= warm_q - 1'b1;
			end
			if (ctrl.upd) begin
				mix_b_q <= mix_c_q + rotl32(mix_d_q, rs[4:0]);
			end
			if (ctrl.c_upd) begin
				mix_c_q <= mix_d_q + t_q;
			end
			if (ctrl.fin) begin
				mix_d_q <= d_new;
				cnt_q   <= step_last ? '0 : cnt_q + 1'b1;
				if (step_last) begin
					rot_q <= mix_c_q[1:0];
					rp_q  <= '0;
				end
			end
		end
	end

	// Request fields and the intermediate difference.
	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			idx_q  <= idx_ext[AW-1:0];
			seed_q <= seed_word;
			mask_q <= byte_mask;
		end
		if (ctrl.upd) begin
			t_q <= pool_rdata - rotl32(mix_b_q, rs[14:10]);
		end
	end

	assign status.mod_done  = mod_done;
	assign status.step_last = step_last;
	assign status.rp_last   = rp_last;
	assign status.warm_zero = (warm_q == '0);
	assign status.idx_ok    = (idx_ext < POOL_LIM);

	assign random_word = buf_rdata;

endmodule

### sv/fsw_ctrl.sv
// Controller state machine sequencing commands, refill steps and warmup.
module fsw_ctrl import fsw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  dp_status_t status,
	output dp_cmd_t    ctrl,
	output logic       busy,
	output logic       result_valid
);

	state_t state_q, state_nx;
	logic   warm_mode_q;
	logic   accept;

	assign accept = start && (state_q == ST_IDLE);

	// State register and warmup-mode flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			warm_mode_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				warm_mode_q <= (cmd_t'(cmd) == CMD_MIX);
			end
		end
	end

	// Next-state logic.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.step_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (cmd_t'(cmd))
						CMD_RESET: state_nx = ST_CLEAR;
						CMD_SEED:  state_nx = status.idx_ok ? ST_SEED_RD : ST_IDLE;
						CMD_MIX:   state_nx = ST_MODD_GO;
						CMD_DRAW:  state_nx = ST_DRAW_RD;
						default:   state_nx = ST_IDLE;
					endcase
				end
			end
			ST_SEED_RD:   state_nx = ST_SEED_WR;
			ST_SEED_WR:   state_nx = ST_IDLE;
			ST_DRAW_RD:   state_nx = ST_DRAW_OUT;
			ST_DRAW_OUT:  state_nx = status.rp_last ? ST_MODD_GO : ST_IDLE;
			ST_MODD_GO:   state_nx = ST_MODD_WAIT;
			ST_MODD_WAIT: begin
				if (status.mod_done) begin
					state_nx = ST_RDP;
				end
			end
			ST_RDP:       state_nx = ST_UPD;
			ST_UPD:       state_nx = ST_MODB_GO;
			ST_MODB_GO:   state_nx = ST_MODB_WAIT;
			ST_MODB_WAIT: begin
				if (status.mod_done) begin
					state_nx = ST_RDB;
				end
			end
			ST_RDB:       state_nx = ST_FIN;
			ST_FIN: begin
				if (status.step_last) begin
					state_nx = warm_mode_q ? ST_WARM : ST_IDLE;
				end else begin
					state_nx = ST_MODD_GO;
				end
			end
			ST_WARM: begin
				if (status.warm_zero) begin
					state_nx = ST_IDLE;
				end else if (status.rp_last) begin
					state_nx = ST_MODD_GO;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_CLEAR: ctrl.clear = 1'b1;
			ST_IDLE: begin
				ctrl.latch     = accept;
				ctrl.warm_load = accept && (cmd_t'(cmd) == CMD_MIX);
			end
			ST_SEED_RD:  ctrl.seed_rd = 1'b1;
			ST_SEED_WR:  ctrl.seed_wr = 1'b1;
			ST_DRAW_OUT: ctrl.draw_out = 1'b1;
			ST_MODD_GO:  ctrl.mod_start = 1'b1;
			ST_UPD:      ctrl.upd = 1'b1;
			ST_MODB_GO: begin
				ctrl.mod_start = 1'b1;
				ctrl.mod_sel_b = 1'b1;
				ctrl.c_upd     = 1'b1;
			end
			ST_FIN:      ctrl.fin = 1'b1;
			ST_WARM:     ctrl.warm_step = !status.warm_zero;
			default:     ctrl = '0;
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_DRAW_OUT);

endmodule

### sv/flea_style_word_generator.sv
// Top level of the keystream word generator: controller plus datapath.
// Draw: the result strobe follows the ST_DRAW_RD buffer read; after the last buffered word
// a refill of POOL_WORDS steps follows, each step making two pool reads through one
// registered RAM port. Seed write: a read-modify-write of one pool word (none past the
// pool). Mix: one refill, then the warmup discards one buffered word per round, with a
// refill at each buffer wrap. Reset or a reset request clears the memories; results are
// never stalled by the receiver.
module flea_style_word_generator import fsw_pkg::*; #(
	parameter int unsigned POOL_WORDS = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        cmd,
	input  logic [6:0]        word_index,
	input  logic [31:0]       seed_word,
	input  logic [3:0]        byte_mask,
	output logic              result_valid,
	output logic [31:0]       random_word,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WARM_W-1:0] warmup_rounds
);

	dp_cmd_t    ctrl;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	fsw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.status       (status),
		.ctrl         (ctrl),
		.busy         (busy),
		.result_valid (result_valid)
	);

	fsw_datapath #(.POOL_WORDS(POOL_WORDS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.word_index  (word_index),
		.seed_word   (seed_word),
		.byte_mask   (byte_mask),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (warmup_rounds),
		.random_word (random_word)
	);

	// A draw request gives its result strobe after the buffer read state.
	a_draw_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_DRAW) |=> ##1 result_valid)
		else $error("draw result strobe missing");

	// A result strobe only appears while a request is in progress.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	// A reset request starts the clearing pass.
	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_RESET) |=> busy)
		else $error("reset request did not start clearing");

	// One strobe per draw.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("repeated result strobe");

endmodule
